/* sv/si_pkg.sv */
// ----------------------------------------------------------------------------
// si_pkg: shared types and constants for the segment intersection block
// Item structs for both channels and default sizes.
// ----------------------------------------------------------------------------
package si_pkg;

    localparam int FIELD_W     = 16;   // width of one input coordinate field
    localparam int OUT_W       = 32;   // width of one output coordinate
    localparam int COORD_W_DEF = 16;
    localparam int FRAC_B_DEF  = 16;

    typedef struct packed {
        logic signed [FIELD_W-1:0] seg1_start_x;
        logic signed [FIELD_W-1:0] seg1_start_y;
        logic signed [FIELD_W-1:0] seg1_end_x;
        logic signed [FIELD_W-1:0] seg1_end_y;
        logic signed [FIELD_W-1:0] seg2_start_x;
        logic signed [FIELD_W-1:0] seg2_start_y;
        logic signed [FIELD_W-1:0] seg2_end_x;
        logic signed [FIELD_W-1:0] seg2_end_y;
    } t_seg_in;

    typedef struct packed {
        logic                    hit;
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
    } t_seg_out;

endpackage

/* sv/si_front.sv */
// ----------------------------------------------------------------------------
// si_front: cross products, range test and dividend products
// Five register stages; all stages move together on i_en.
// ----------------------------------------------------------------------------
module si_front import si_pkg::*; #(
    parameter int COORD_WIDTH = COORD_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  t_seg_in                           i_item,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic                              o_neg_x,
    output logic                              o_neg_y,
    output logic signed [COORD_WIDTH-1:0]     o_px,
    output logic signed [COORD_WIDTH-1:0]     o_py,
    output logic [3*COORD_WIDTH:0]            o_nx,
    output logic [3*COORD_WIDTH:0]            o_ny,
    output logic [2*COORD_WIDTH:0]            o_den
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;       // endpoint difference
    localparam int PW = 2 * CW + 2;   // one product
    localparam int SW = 2 * CW + 3;   // cross product
    localparam int MW = 2 * CW + 1;   // cross product magnitude
    localparam int NW = MW + CW;      // dividend product

    function automatic logic signed [CW-1:0] take(input logic [FIELD_W-1:0] f);
        logic [CW+FIELD_W-1:0] t;
        t = {{CW{1'b0}}, f};
        return signed'(t[CW-1:0]);
    endfunction

    logic [4:0] r_vld;

    // stage 1
    logic signed [CW-1:0] r1_px, r1_py;
    logic signed [DW-1:0] r1_rx, r1_ry, r1_sx, r1_sy, r1_mx, r1_my;
    // stage 2
    logic signed [CW-1:0] r2_px, r2_py;
    logic signed [DW-1:0] r2_rx, r2_ry;
    logic signed [PW-1:0] r2_a, r2_b, r2_c, r2_d, r2_e, r2_f;
    // stage 3
    logic signed [CW-1:0] r3_px, r3_py;
    logic signed [DW-1:0] r3_rx, r3_ry;
    logic signed [SW-1:0] r3_den, r3_tn, r3_un;
    // stage 4
    logic signed [CW-1:0] r4_px, r4_py;
    logic [MW-1:0]        r4_tm, r4_dm;
    logic [CW-1:0]        r4_rxm, r4_rym;
    logic                 r4_hit, r4_nx, r4_ny;
    // stage 5
    logic signed [CW-1:0] r5_px, r5_py;
    logic [NW-1:0]        r5_nx, r5_ny;
    logic [MW-1:0]        r5_dm;
    logic                 r5_hit, r5_negx, r5_negy;

    logic signed [CW-1:0] n_p1x, n_p1y, n_e1x, n_e1y, n_q2x, n_q2y, n_e2x, n_e2y;
    logic                 n_hit, n_tin, n_uin;
    logic signed [SW-1:0] n_tabs, n_dabs;
    logic signed [DW-1:0] n_rxa, n_rya;

    always_comb begin
        n_p1x = take(i_item.seg1_start_x);
        n_p1y = take(i_item.seg1_start_y);
        n_e1x = take(i_item.seg1_end_x);
        n_e1y = take(i_item.seg1_end_y);
        n_q2x = take(i_item.seg2_start_x);
        n_q2y = take(i_item.seg2_start_y);
        n_e2x = take(i_item.seg2_end_x);
        n_e2y = take(i_item.seg2_end_y);
        // t and u in [0,1], exact on signs
        if (r3_den > 0) begin
            n_tin = (r3_tn >= 0) && (r3_tn <= r3_den);
            n_uin = (r3_un >= 0) && (r3_un <= r3_den);
        end else begin
            n_tin = (r3_tn <= 0) && (r3_tn >= r3_den);
            n_uin = (r3_un <= 0) && (r3_un >= r3_den);
        end
        n_hit  = (r3_den != 0) && n_tin && n_uin;
        n_tabs = r3_tn[SW-1]  ? -r3_tn  : r3_tn;
        n_dabs = r3_den[SW-1] ? -r3_den : r3_den;
        n_rxa  = r3_rx[DW-1]  ? -r3_rx  : r3_rx;
        n_rya  = r3_ry[DW-1]  ? -r3_ry  : r3_ry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_px <= n_p1x;
            r1_py <= n_p1y;
            r1_rx <= DW'(n_e1x) - DW'(n_p1x);
            r1_ry <= DW'(n_e1y) - DW'(n_p1y);
            r1_sx <= DW'(n_e2x) - DW'(n_q2x);
            r1_sy <= DW'(n_e2y) - DW'(n_q2y);
            r1_mx <= DW'(n_q2x) - DW'(n_p1x);
            r1_my <= DW'(n_q2y) - DW'(n_p1y);

            r2_px <= r1_px;
            r2_py <= r1_py;
            r2_rx <= r1_rx;
            r2_ry <= r1_ry;
            r2_a  <= PW'(r1_rx) * PW'(r1_sy);
            r2_b  <= PW'(r1_ry) * PW'(r1_sx);
            r2_c  <= PW'(r1_mx) * PW'(r1_sy);
            r2_d  <= PW'(r1_my) * PW'(r1_sx);
            r2_e  <= PW'(r1_mx) * PW'(r1_ry);
            r2_f  <= PW'(r1_my) * PW'(r1_rx);

            r3_px  <= r2_px;
            r3_py  <= r2_py;
            r3_rx  <= r2_rx;
            r3_ry  <= r2_ry;
            r3_den <= SW'(r2_a) - SW'(r2_b);
            r3_tn  <= SW'(r2_c) - SW'(r2_d);
            r3_un  <= SW'(r2_e) - SW'(r2_f);

            r4_px  <= r3_px;
            r4_py  <= r3_py;
            r4_tm  <= n_tabs[MW-1:0];
            r4_dm  <= n_dabs[MW-1:0];
            r4_rxm <= n_rxa[CW-1:0];
            r4_rym <= n_rya[CW-1:0];
            r4_hit <= n_hit;
            r4_nx  <= r3_tn[SW-1] ^ r3_rx[DW-1] ^ r3_den[SW-1];
            r4_ny  <= r3_tn[SW-1] ^ r3_ry[DW-1] ^ r3_den[SW-1];

            r5_px   <= r4_px;
            r5_py   <= r4_py;
            r5_nx   <= NW'(r4_tm) * NW'(r4_rxm);
            r5_ny   <= NW'(r4_tm) * NW'(r4_rym);
            r5_dm   <= r4_dm;
            r5_hit  <= r4_hit;
            r5_negx <= r4_nx;
            r5_negy <= r4_ny;
        end
    end

    assign o_valid = r_vld[4];
    assign o_hit   = r5_hit;
    assign o_neg_x = r5_negx;
    assign o_neg_y = r5_negy;
    assign o_px    = r5_px;
    assign o_py    = r5_py;
    assign o_nx    = r5_nx;
    assign o_ny    = r5_ny;
    assign o_den   = r5_dm;

endmodule

/* sv/si_div.sv */
// ----------------------------------------------------------------------------
// si_div: pipelined restoring divider, x and y lanes side by side
// One quotient bit per stage; all stages move together on i_en.
// ----------------------------------------------------------------------------
module si_div import si_pkg::*; #(
    parameter int COORD_WIDTH = COORD_W_DEF,
    parameter int FRAC_BITS   = FRAC_B_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic                              i_hit,
    input  logic                              i_neg_x,
    input  logic                              i_neg_y,
    input  logic signed [COORD_WIDTH-1:0]     i_px,
    input  logic signed [COORD_WIDTH-1:0]     i_py,
    input  logic [3*COORD_WIDTH:0]            i_nx,
    input  logic [3*COORD_WIDTH:0]            i_ny,
    input  logic [2*COORD_WIDTH:0]            i_den,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic                              o_neg_x,
    output logic                              o_neg_y,
    output logic signed [COORD_WIDTH-1:0]     o_px,
    output logic signed [COORD_WIDTH-1:0]     o_py,
    output logic [COORD_WIDTH+FRAC_BITS-1:0]  o_qx,
    output logic [COORD_WIDTH+FRAC_BITS-1:0]  o_qy
);

    localparam int CW = COORD_WIDTH;
    localparam int MW = 2 * CW + 1;
    localparam int QW = CW + FRAC_BITS;

    logic [QW-1:0]        r_vld;
    logic [MW-1:0]        r_remx [QW];
    logic [MW-1:0]        r_remy [QW];
    logic [QW-1:0]        r_lowx [QW];
    logic [QW-1:0]        r_lowy [QW];
    logic [MW-1:0]        r_den  [QW];
    logic [QW-1:0]        r_hit, r_ngx, r_ngy;
    logic signed [CW-1:0] r_px   [QW];
    logic signed [CW-1:0] r_py   [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [MW-1:0]        n_rx, n_ry, n_d;
        logic [QW-1:0]        n_lx, n_ly;
        logic [MW:0]          n_tx, n_ty, n_dx;
        logic                 n_gx, n_gy;
        logic                 n_h, n_ngx, n_ngy;
        logic signed [CW-1:0] n_x, n_y;

        if (k == 0) begin : g_first
            // integer part of the dividend is already below the divisor
            assign n_rx  = i_nx[MW+CW-1:CW];
            assign n_ry  = i_ny[MW+CW-1:CW];
            assign n_lx  = {i_nx[CW-1:0], {FRAC_BITS{1'b0}}};
            assign n_ly  = {i_ny[CW-1:0], {FRAC_BITS{1'b0}}};
            assign n_d   = i_den;
            assign n_h   = i_hit;
            assign n_ngx = i_neg_x;
            assign n_ngy = i_neg_y;
            assign n_x   = i_px;
            assign n_y   = i_py;
        end else begin : g_next
            assign n_rx  = r_remx[k-1];
            assign n_ry  = r_remy[k-1];
            assign n_lx  = r_lowx[k-1];
            assign n_ly  = r_lowy[k-1];
            assign n_d   = r_den[k-1];
            assign n_h   = r_hit[k-1];
            assign n_ngx = r_ngx[k-1];
            assign n_ngy = r_ngy[k-1];
            assign n_x   = r_px[k-1];
            assign n_y   = r_py[k-1];
        end

        always_comb begin
            n_dx = {1'b0, n_d};
            n_tx = {n_rx, n_lx[QW-1]};
            n_ty = {n_ry, n_ly[QW-1]};
            n_gx = n_tx >= n_dx;
            n_gy = n_ty >= n_dx;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_remx[k] <= n_gx ? MW'(n_tx - n_dx) : n_tx[MW-1:0];
                r_remy[k] <= n_gy ? MW'(n_ty - n_dx) : n_ty[MW-1:0];
                r_lowx[k] <= {n_lx[QW-2:0], n_gx};
                r_lowy[k] <= {n_ly[QW-2:0], n_gy};
                r_den[k]  <= n_d;
                r_hit[k]  <= n_h;
                r_ngx[k]  <= n_ngx;
                r_ngy[k]  <= n_ngy;
                r_px[k]   <= n_x;
                r_py[k]   <= n_y;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_hit   = r_hit[QW-1];
    assign o_neg_x = r_ngx[QW-1];
    assign o_neg_y = r_ngy[QW-1];
    assign o_px    = r_px[QW-1];
    assign o_py    = r_py[QW-1];
    assign o_qx    = r_lowx[QW-1];
    assign o_qy    = r_lowy[QW-1];

endmodule

/* sv/segment_intersection.sv */
// ----------------------------------------------------------------------------
// segment_intersection: exact 2D segment crossing test
// Parametric cross-product test with the crossing point in fixed point.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  input   | in        | i_valid / o_ready  | i_item  (t_seg_in, 8 coords)
//  result  | out       | o_valid / i_ready  | o_item  (t_seg_out)
//
//  The path holds five front stages, one divider stage per quotient bit
//  (COORD_WIDTH + FRAC_BITS of them) and one output stage.
//  One item is taken per cycle unless a stall refuses input; the bit-per-stage divider sets the depth.
//  Reset (synchronous, active low) clears only the valid bits.
//  A stall on the result side freezes the output register, and the divider and front
//  too once their last stages hold items; input is refused only while all three are held.
//
module segment_intersection import si_pkg::*; #(
    parameter int COORD_WIDTH = COORD_W_DEF,
    parameter int FRAC_BITS   = FRAC_B_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_seg_in  i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_seg_out o_item
);

    localparam int CW = COORD_WIDTH;
    localparam int QW = CW + FRAC_BITS;
    localparam int XW = CW + FRAC_BITS + 2;   // start point plus offset

    // front -> divider
    logic                 f_valid, f_hit, f_negx, f_negy;
    logic signed [CW-1:0] f_px, f_py;
    logic [3*CW:0]        f_nx, f_ny;
    logic [2*CW:0]        f_den;
    // divider -> output
    logic                 d_valid, d_hit, d_negx, d_negy;
    logic signed [CW-1:0] d_px, d_py;
    logic [QW-1:0]        d_qx, d_qy;

    logic     en_out, en_div, en_front;
    logic     r_valid;
    t_seg_out r_item;

    // each section moves when its last stage is empty or drains downstream
    assign en_out   = !r_valid || i_ready;
    assign en_div   = !d_valid || en_out;
    assign en_front = !f_valid || en_div;

    si_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_front),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_hit   (f_hit),
        .o_neg_x (f_negx),
        .o_neg_y (f_negy),
        .o_px    (f_px),
        .o_py    (f_py),
        .o_nx    (f_nx),
        .o_ny    (f_ny),
        .o_den   (f_den)
    );

    si_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_div),
        .i_valid (f_valid),
        .i_hit   (f_hit),
        .i_neg_x (f_negx),
        .i_neg_y (f_negy),
        .i_px    (f_px),
        .i_py    (f_py),
        .i_nx    (f_nx),
        .i_ny    (f_ny),
        .i_den   (f_den),
        .o_valid (d_valid),
        .o_hit   (d_hit),
        .o_neg_x (d_negx),
        .o_neg_y (d_negy),
        .o_px    (d_px),
        .o_py    (d_py),
        .o_qx    (d_qx),
        .o_qy    (d_qy)
    );

    // point = start << FRAC_BITS plus the signed, truncated offset
    logic signed [XW-1:0] n_ox, n_oy, n_bx, n_by, n_cx, n_cy;
    t_seg_out             n_item;

    always_comb begin
        n_ox = signed'({2'b00, d_qx});
        n_oy = signed'({2'b00, d_qy});
        if (d_negx) begin
            n_ox = -n_ox;
        end
        if (d_negy) begin
            n_oy = -n_oy;
        end
        n_bx = XW'(d_px) <<< FRAC_BITS;
        n_by = XW'(d_py) <<< FRAC_BITS;
        n_cx = n_bx + n_ox;
        n_cy = n_by + n_oy;
        n_item = '0;
        if (d_hit) begin   // a miss reports zeros
            n_item.hit     = 1'b1;
            n_item.cross_x = OUT_W'(n_cx);
            n_item.cross_y = OUT_W'(n_cy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en_out) begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_item <= n_item;
        end
    end

    assign o_ready = en_front;
    assign o_valid = r_valid;
    assign o_item  = r_item;

`ifndef ASSERT_OFF
    // input is held back only when every section is full and blocked
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a blocked result");

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.hit) |-> (o_item.cross_x == '0 && o_item.cross_y == '0))
        else $error("miss with nonzero point");
`endif

endmodule

/* dv/segment_intersection_checker.sv */
// ----------------------------------------------------------------------------
// segment_intersection_checker: result predictor and scoreboard
// Watches both channels, computes the expected crossing for every accepted
// input item, and compares each result item field by field in order.
// ----------------------------------------------------------------------------
module segment_intersection_checker import si_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_seg_in  i_in_item,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_seg_out i_out_item,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_hits,
    output int       o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_W_DEF;
    localparam int FB = FRAC_B_DEF;

    t_seg_out crossing_q[$];

    function automatic longint coord(input logic [FIELD_W-1:0] v);
        logic signed [CW-1:0] c;
        c = v[CW-1:0];
        return longint'(c);
    endfunction

    function automatic logic within_unit(input longint n, input longint d);
        if (d > 0) return n >= 0 && n <= d;
        return n <= 0 && n >= d;
    endfunction

    // trunc(num*r*2^FB/den); magnitudes fit comfortably in 128 bits
    function automatic longint offset_q(input longint num, input longint r,
                                        input longint den);
        logic signed [127:0] prod;
        logic signed [127:0] quo;
        prod = (128'(signed'(num)) * 128'(signed'(r))) <<< FB;
        quo  = prod / 128'(signed'(den));   // SV division truncates toward zero
        return longint'(quo);
    endfunction

    function automatic t_seg_out crossing(input t_seg_in s);
        t_seg_out r;
        longint px, py, rx, ry, qx, qy, sx, sy, den, mx, my, tn, un;
        px = coord(s.seg1_start_x);  py = coord(s.seg1_start_y);
        rx = coord(s.seg1_end_x) - px;  ry = coord(s.seg1_end_y) - py;
        qx = coord(s.seg2_start_x);  qy = coord(s.seg2_start_y);
        sx = coord(s.seg2_end_x) - qx;  sy = coord(s.seg2_end_y) - qy;
        den = rx * sy - ry * sx;
        mx = qx - px;  my = qy - py;
        tn = mx * sy - my * sx;
        un = mx * ry - my * rx;
        r = '0;
        if (den != 0 && within_unit(tn, den) && within_unit(un, den)) begin
            r.hit     = 1'b1;
            r.cross_x = OUT_W'((px <<< FB) + offset_q(tn, rx, den));
            r.cross_y = OUT_W'((py <<< FB) + offset_q(tn, ry, den));
        end
        return r;
    endfunction

    assign o_pending = crossing_q.size();

    always @(posedge i_clk) begin
        t_seg_out want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_hits       <= 0;
            o_results    <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                crossing_q.push_back(crossing(i_in_item));
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (crossing_q.size() == 0) begin
                    $display("%0t: unexpected result item %p", $time, i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = crossing_q.pop_front();
                    if (want.hit) o_hits <= o_hits + 1;
                    if (want.hit !== i_out_item.hit ||
                        want.cross_x !== i_out_item.cross_x ||
                        want.cross_y !== i_out_item.cross_y) begin
                        $display({"%0t: mismatch expected hit=%0b x=%0d y=%0d",
                                  " actual hit=%0b x=%0d y=%0d"},
                                 $time, want.hit, want.cross_x, want.cross_y,
                                 i_out_item.hit, i_out_item.cross_x,
                                 i_out_item.cross_y);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* dv/tb_segment_intersection.sv */
// ----------------------------------------------------------------------------
// tb_segment_intersection: stimulus and verdict for segment_intersection
// Directed corner pairs then random pairs (mostly crossing-prone), with
// bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_segment_intersection;
    import si_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 930;
    localparam int LATENCY  = 5 + COORD_W_DEF + FRAC_B_DEF + 1;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_seg_in  i_item;
    logic     o_valid;
    logic     i_ready;
    t_seg_out o_item;
    int       fail_count, pending, hit_count, result_count;
    bit       hold_off;
    bit       stim_done;

    segment_intersection DUT (.*);

    segment_intersection_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid (i_valid), .i_in_ready (o_ready), .i_in_item (i_item),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_item(o_item),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_hits(hit_count), .o_results(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: ends the run with an error if it has not finished
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_seg_in make_pair(input int a, b, c, d, e, f, g, h);
        t_seg_in s;
        s.seg1_start_x = 16'(a);  s.seg1_start_y = 16'(b);
        s.seg1_end_x   = 16'(c);  s.seg1_end_y   = 16'(d);
        s.seg2_start_x = 16'(e);  s.seg2_start_y = 16'(f);
        s.seg2_end_x   = 16'(g);  s.seg2_end_y   = 16'(h);
        return s;
    endfunction

    function automatic logic [15:0] rnd_coord(input int span);
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    // Random pair; most are built so the segments likely cross
    function automatic t_seg_in random_pair();
        t_seg_in s;
        int span, kind;
        kind = $urandom_range(9);
        span = kind < 2 ? 0 : (kind < 5 ? 40 : 2000);
        if (kind == 9) span = 32767;
        s = t_seg_in'({$urandom, $urandom, $urandom, $urandom});
        if (span != 0) begin
            s.seg1_start_x = rnd_coord(span);  s.seg1_end_x = -rnd_coord(span);
            s.seg1_start_y = rnd_coord(span);  s.seg1_end_y = -rnd_coord(span);
            s.seg2_start_x = rnd_coord(span);  s.seg2_end_x = -rnd_coord(span);
            s.seg2_start_y = rnd_coord(span);  s.seg2_end_y = -rnd_coord(span);
            // occasional shared endpoint or parallel copy
            if ($urandom_range(7) == 0) begin
                s.seg2_start_x = s.seg1_end_x;  s.seg2_start_y = s.seg1_end_y;
            end else if ($urandom_range(7) == 0) begin
                s.seg2_end_x = s.seg2_start_x + (s.seg1_end_x - s.seg1_start_x);
                s.seg2_end_y = s.seg2_start_y + (s.seg1_end_y - s.seg1_start_y);
            end
        end
        return s;
    endfunction

    task automatic send_item(input t_seg_in s);
        i_valid <= 1'b1;
        i_item  <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Receiver: random stall pattern plus one long hold-off
    initial begin
        int phase;
        i_ready = 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_off) i_ready <= 1'b0;
            else if (phase % 300 < 60) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(3) != 0);
        end
    end

    initial begin
        t_seg_in dir_q[$];
        int burst, n, waited;
        bit held;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_item   = '0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        held     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // simple X crossing
        dir_q.push_back(make_pair(-10, -10, 10, 10, -10, 10, 10, -10));
        // non-integer crossing
        dir_q.push_back(make_pair(0, 0, 3, 1, 1, 0, 0, 7));
        // parallel and collinear overlapping
        dir_q.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        dir_q.push_back(make_pair(0, 0, 10, 0, 5, 0, 20, 0));
        // degenerate point segments
        dir_q.push_back(make_pair(3, 3, 3, 3, 0, 0, 9, 9));
        dir_q.push_back(make_pair(3, 3, 3, 3, 3, 3, 3, 3));
        // endpoint touches: t=0, t=1, u=0, u=1
        dir_q.push_back(make_pair(0, 0, 10, 0, 0, -5, 0, 5));
        dir_q.push_back(make_pair(0, 0, 10, 0, 10, -5, 10, 5));
        dir_q.push_back(make_pair(0, -5, 0, 5, 0, 0, 10, 0));
        dir_q.push_back(make_pair(0, -5, 0, 5, 10, 0, 0, 0));
        // just missing, both with a positive denominator
        dir_q.push_back(make_pair(0, 0, 10, 0, 11, -5, 11, 5));
        dir_q.push_back(make_pair(0, 0, 10, 0, 5, 1, 5, 9));
        // full-range extremes
        dir_q.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        dir_q.push_back(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32766));
        dir_q.push_back(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        dir_q.push_back(make_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        dir_q.push_back(make_pair(-1, -1, -1, -1, 0, 0, 0, 0));
        dir_q.push_back(make_pair(0, 0, 0, 0, -1, -1, -1, -1));
        foreach (dir_q[k]) send_item(dir_q[k]);
        idle_gap(1);

        // random bursts; one long receiver hold-off while sending
        n = 0;
        while (n < N_RANDOM) begin
            if (n >= 300 && !held) begin
                held = 1'b1;
                hold_off = 1'b1;
                fork
                    begin
                        repeat (400) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            burst = $urandom_range(1, 2) == 1 ? $urandom_range(1, 8) : $urandom_range(20, 80);
            repeat (burst) begin
                if (n < N_RANDOM) send_item(random_pair());
                n++;
            end
            if ($urandom_range(3) != 0) idle_gap($urandom_range(1, 12));
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;

        waited = 0;
        while (pending != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d directed and %0d random segment pairs; %0d results, %0d crossings.",
                 dir_q.size(), N_RANDOM, result_count, hit_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/si_pkg.sv
sv/si_front.sv
sv/si_div.sv
sv/segment_intersection.sv
dv/segment_intersection_checker.sv
dv/tb_segment_intersection.sv
